@@ hdl/rv_alu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the RV32IM execute ALU.
// Used by every module of the block; it depends on nothing.
package rv_alu_pkg;

  // Operation codes.
  localparam logic [4:0] OP_OR     = 5'd0;
  localparam logic [4:0] OP_AND    = 5'd1;
  localparam logic [4:0] OP_XOR    = 5'd2;
  localparam logic [4:0] OP_ADD    = 5'd3;
  localparam logic [4:0] OP_SUB    = 5'd4;
  localparam logic [4:0] OP_SLL    = 5'd5;
  localparam logic [4:0] OP_SRL    = 5'd6;
  localparam logic [4:0] OP_SRA    = 5'd7;
  localparam logic [4:0] OP_SLT    = 5'd8;
  localparam logic [4:0] OP_SLTU   = 5'd9;
  localparam logic [4:0] OP_JALR   = 5'd10;
  localparam logic [4:0] OP_MULH   = 5'd11;
  localparam logic [4:0] OP_MULHSU = 5'd12;
  localparam logic [4:0] OP_MULHU  = 5'd13;
  localparam logic [4:0] OP_MUL    = 5'd14;
  localparam logic [4:0] OP_DIVU   = 5'd15;
  localparam logic [4:0] OP_REMU   = 5'd16;
  localparam logic [4:0] OP_DIV    = 5'd17;
  localparam logic [4:0] OP_REM    = 5'd18;
  localparam logic [4:0] OP_BEQ    = 5'd19;
  localparam logic [4:0] OP_BNE    = 5'd20;
  localparam logic [4:0] OP_BLT    = 5'd21;
  localparam logic [4:0] OP_BLTU   = 5'd22;
  localparam logic [4:0] OP_BGE    = 5'd23;
  localparam logic [4:0] OP_BGEU   = 5'd24;

  // Execution classes chosen by the front end.
  localparam logic [1:0] CLS_ALU = 2'd0;
  localparam logic [1:0] CLS_MUL = 2'd1;
  localparam logic [1:0] CLS_DIV = 2'd2;
  localparam logic [1:0] CLS_BR  = 2'd3;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        branch_taken;
  } out_item_t;

  // Classified command passed through the queue.
  typedef struct packed {
    logic [1:0]  cls;
    logic        a_signed;
    logic        b_signed;
    logic [4:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } cmd_t;

endpackage

@@ hdl/rv32im_execute_alu.sv @@
`timescale 1ns / 1ps
// RV32IM execute ALU: front end, command queue and pipelined back end.
// Depends on rv_alu_pkg, rv_alu_front, rv_alu_queue and rv_alu_back.
//
// One item is accepted per cycle (start high while busy is low) and every
// item, whatever its operation, gives exactly one result, strobed by
// out_valid for one cycle, in acceptance order. The latency is set by the
// divider, which resolves one quotient bit per pipeline stage over 32
// stages; all operations share that pipeline so results stay in order. The
// back end never stalls, so busy only rises if the queue fills.
module rv32im_execute_alu #(
  parameter int QDEPTH = rv_alu_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rv_alu_pkg::in_item_t  in_data,
  output logic                  out_valid,
  output rv_alu_pkg::out_item_t out_data
);

  logic                        accept;
  logic                        cmd_valid;
  rv_alu_pkg::cmd_t            cmd;
  logic                        q_not_empty;
  rv_alu_pkg::cmd_t            q_head;
  logic [$clog2(QDEPTH+1)-1:0] q_count;

  assign accept = start && !busy;
  // Leave room for the command still held in the front register.
  assign busy   = (32'(q_count) + 32'(cmd_valid)) >= 32'(QDEPTH);

  rv_alu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  rv_alu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_valid),
    .push_cmd  (cmd),
    .pop       (q_not_empty),
    .not_empty (q_not_empty),
    .head_cmd  (q_head),
    .count     (q_count)
  );

  rv_alu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

@@ hdl/rv_alu_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts items and classifies them into commands.
// Depends on rv_alu_pkg.
module rv_alu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  rv_alu_pkg::in_item_t in_item,
  output logic                 cmd_valid,
  output rv_alu_pkg::cmd_t     cmd
);

  logic             valid_r;
  rv_alu_pkg::cmd_t cmd_r;
  rv_alu_pkg::cmd_t cmd_nxt;

  // Decode class and operand signedness.
  always_comb begin
    cmd_nxt.op = in_item.op;
    cmd_nxt.a  = in_item.operand_a;
    cmd_nxt.b  = in_item.operand_b;
    cmd_nxt.a_signed = (in_item.op == rv_alu_pkg::OP_MULH) ||
                       (in_item.op == rv_alu_pkg::OP_MULHSU) ||
                       (in_item.op == rv_alu_pkg::OP_DIV) ||
                       (in_item.op == rv_alu_pkg::OP_REM);
    cmd_nxt.b_signed = (in_item.op == rv_alu_pkg::OP_MULH) ||
                       (in_item.op == rv_alu_pkg::OP_DIV) ||
                       (in_item.op == rv_alu_pkg::OP_REM);
    if (in_item.op inside {[rv_alu_pkg::OP_MULH:rv_alu_pkg::OP_MUL]}) begin
      cmd_nxt.cls = rv_alu_pkg::CLS_MUL;
    end else if (in_item.op inside {[rv_alu_pkg::OP_DIVU:rv_alu_pkg::OP_REM]}) begin
      cmd_nxt.cls = rv_alu_pkg::CLS_DIV;
    end else if (in_item.op inside {[rv_alu_pkg::OP_BEQ:rv_alu_pkg::OP_BGEU]}) begin
      cmd_nxt.cls = rv_alu_pkg::CLS_BR;
    end else begin
      cmd_nxt.cls = rv_alu_pkg::CLS_ALU;
    end
  end

  // Command register feeding the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

@@ hdl/rv_alu_queue.sv @@
`timescale 1ns / 1ps
// Small command queue between the front end and the execution back end.
// Depends on rv_alu_pkg.
module rv_alu_queue #(
  parameter int DEPTH = rv_alu_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  rv_alu_pkg::cmd_t         push_cmd,
  input  logic                     pop,
  output logic                     not_empty,
  output rv_alu_pkg::cmd_t         head_cmd,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rv_alu_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

@@ hdl/rv_alu_back.sv @@
`timescale 1ns / 1ps
// Execution back end: ALU, branch compare, multiplier and a pipelined
// one-bit-per-stage divider, all on one fixed-latency pipeline. Depends on rv_alu_pkg.
module rv_alu_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  rv_alu_pkg::cmd_t      cmd,
  output logic                  out_valid,
  output rv_alu_pkg::out_item_t out_item
);

  localparam int NSTAGE = 32;

  typedef struct packed {
    logic [1:0]  cls;
    logic        hi;
    logic        neg_q;
    logic        neg_r;
    logic        taken;
    logic [31:0] res;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } stage_t;

  logic   vld_r [NSTAGE+1];
  stage_t stg_r [NSTAGE+1];
  stage_t stg0_nxt;
  logic [63:0] prod_r;
  logic signed [65:0] prod_full;
  logic [4:0]  sh;
  logic        lt_s;
  logic        lt_u;

  assign sh   = cmd.b[4:0];
  assign lt_s = $signed(cmd.a) < $signed(cmd.b);
  assign lt_u = cmd.a < cmd.b;
  assign prod_full = $signed({cmd.a_signed & cmd.a[31], cmd.a}) *
                     $signed({cmd.b_signed & cmd.b[31], cmd.b});

  // First stage: simple ops, branch compare and divider setup.
  always_comb begin
    stg0_nxt       = '0;
    stg0_nxt.cls   = cmd.cls;
    stg0_nxt.hi    = (cmd.op == rv_alu_pkg::OP_MULH) ||
                     (cmd.op == rv_alu_pkg::OP_MULHSU) ||
                     (cmd.op == rv_alu_pkg::OP_MULHU) ||
                     (cmd.op == rv_alu_pkg::OP_REMU) ||
                     (cmd.op == rv_alu_pkg::OP_REM);
    stg0_nxt.quo   = (cmd.a_signed && cmd.a[31]) ? 32'(0 - cmd.a) : cmd.a;
    stg0_nxt.dvs   = (cmd.b_signed && cmd.b[31]) ? 32'(0 - cmd.b) : cmd.b;
    stg0_nxt.neg_q = cmd.a_signed && (cmd.a[31] ^ cmd.b[31]) && (cmd.b != '0);
    stg0_nxt.neg_r = cmd.a_signed && cmd.a[31];
    case (cmd.op)
      rv_alu_pkg::OP_OR:   stg0_nxt.res = cmd.a | cmd.b;
      rv_alu_pkg::OP_AND:  stg0_nxt.res = cmd.a & cmd.b;
      rv_alu_pkg::OP_XOR:  stg0_nxt.res = cmd.a ^ cmd.b;
      rv_alu_pkg::OP_ADD:  stg0_nxt.res = cmd.a + cmd.b;
      rv_alu_pkg::OP_SUB:  stg0_nxt.res = cmd.a - cmd.b;
      rv_alu_pkg::OP_SLL:  stg0_nxt.res = cmd.a << sh;
      rv_alu_pkg::OP_SRL:  stg0_nxt.res = cmd.a >> sh;
      rv_alu_pkg::OP_SRA:  stg0_nxt.res = 32'($signed(cmd.a) >>> sh);
      rv_alu_pkg::OP_SLT:  stg0_nxt.res = {31'd0, lt_s};
      rv_alu_pkg::OP_SLTU: stg0_nxt.res = {31'd0, lt_u};
      rv_alu_pkg::OP_JALR: stg0_nxt.res = (cmd.a + cmd.b) & ~32'd1;
      rv_alu_pkg::OP_BEQ:  stg0_nxt.taken = (cmd.a == cmd.b);
      rv_alu_pkg::OP_BNE:  stg0_nxt.taken = (cmd.a != cmd.b);
      rv_alu_pkg::OP_BLT:  stg0_nxt.taken = lt_s;
      rv_alu_pkg::OP_BLTU: stg0_nxt.taken = lt_u;
      rv_alu_pkg::OP_BGE:  stg0_nxt.taken = !lt_s;
      rv_alu_pkg::OP_BGEU: stg0_nxt.taken = !lt_u;
      default:             stg0_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= cmd_valid;
    end
    stg_r[0] <= stg0_nxt;
    prod_r   <= prod_full[63:0];
  end

  // Divider stages; the first one also picks the product half.
  for (genvar k = 1; k <= NSTAGE; k++) begin : g_stage
    stage_t      s_nxt;
    logic [33:0] diff;

    always_comb begin
      s_nxt = stg_r[k-1];
      diff  = {1'b0, stg_r[k-1].rem, stg_r[k-1].quo[31]} - {2'b00, stg_r[k-1].dvs};
      if (stg_r[k-1].cls == rv_alu_pkg::CLS_DIV) begin
        if (!diff[33]) begin
          s_nxt.rem = diff[31:0];
          s_nxt.quo = {stg_r[k-1].quo[30:0], 1'b1};
        end else begin
          s_nxt.rem = {stg_r[k-1].rem[30:0], stg_r[k-1].quo[31]};
          s_nxt.quo = {stg_r[k-1].quo[30:0], 1'b0};
        end
      end
      if (k == 1 && stg_r[k-1].cls == rv_alu_pkg::CLS_MUL) begin
        s_nxt.res = stg_r[k-1].hi ? prod_r[63:32] : prod_r[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      stg_r[k] <= s_nxt;
    end
  end

  // Output register with divider sign fixup.
  logic                  out_valid_r;
  rv_alu_pkg::out_item_t out_item_r, out_item_nxt;
  stage_t                last;

  assign last = stg_r[NSTAGE];

  always_comb begin
    out_item_nxt.branch_taken = 1'b0;
    out_item_nxt.result       = last.res;
    case (last.cls)
      rv_alu_pkg::CLS_DIV: begin
        if (last.hi) begin
          out_item_nxt.result = last.neg_r ? 32'(0 - last.rem) : last.rem;
        end else begin
          out_item_nxt.result = last.neg_q ? 32'(0 - last.quo) : last.quo;
        end
      end
      rv_alu_pkg::CLS_BR: begin
        out_item_nxt.result       = '0;
        out_item_nxt.branch_taken = last.taken;
      end
      default: out_item_nxt.result = last.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NSTAGE];
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ tb/rv32im_alu_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RV32IM execute ALU: watches accepted items and strobed results.
// Depends on rv_alu_pkg; predicts each result and compares it in order.
module rv32im_alu_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  rv_alu_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  rv_alu_pkg::out_item_t out_data,
  output int                    fail_count,
  output int                    pending
);

  rv_alu_pkg::out_item_t expected_q[$];

  // Signed compare of two 32-bit words.
  function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Computes the result that the block should give for one item.
  function automatic rv_alu_pkg::out_item_t alu_predict(rv_alu_pkg::in_item_t it);
    rv_alu_pkg::out_item_t r;
    logic [31:0] a, b, ma, mb, q;
    logic [4:0] sh;
    logic signed [63:0] sprod;
    logic [63:0] uprod;
    a = it.operand_a;
    b = it.operand_b;
    sh = b[4:0];
    r.result = '0;
    r.branch_taken = 1'b0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (it.op)
      rv_alu_pkg::OP_OR:   r.result = a | b;
      rv_alu_pkg::OP_AND:  r.result = a & b;
      rv_alu_pkg::OP_XOR:  r.result = a ^ b;
      rv_alu_pkg::OP_ADD:  r.result = a + b;
      rv_alu_pkg::OP_SUB:  r.result = a - b;
      rv_alu_pkg::OP_SLL:  r.result = a << sh;
      rv_alu_pkg::OP_SRL:  r.result = a >> sh;
      rv_alu_pkg::OP_SRA:  r.result = $signed(a) >>> sh;
      rv_alu_pkg::OP_SLT:  r.result = {31'd0, signed_less(a, b)};
      rv_alu_pkg::OP_SLTU: r.result = {31'd0, a < b};
      rv_alu_pkg::OP_JALR: r.result = (a + b) & ~32'd1;
      rv_alu_pkg::OP_MULH: begin
        sprod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        r.result = sprod[63:32];
      end
      rv_alu_pkg::OP_MULHSU: begin
        sprod = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
        r.result = sprod[63:32];
      end
      rv_alu_pkg::OP_MULHU: begin
        uprod = {32'd0, a} * {32'd0, b};
        r.result = uprod[63:32];
      end
      rv_alu_pkg::OP_MUL:  r.result = a * b;
      rv_alu_pkg::OP_DIVU: r.result = (b == 0) ? 32'hFFFF_FFFF : a / b;
      rv_alu_pkg::OP_REMU: r.result = (b == 0) ? a : a % b;
      rv_alu_pkg::OP_DIV: begin
        // Divide by zero gives all ones; the overflow case gives the dividend.
        if (b == 0) r.result = 32'hFFFF_FFFF;
        else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r.result = a;
        else begin
          q = ma / mb;
          r.result = (a[31] ^ b[31]) ? -q : q;
        end
      end
      rv_alu_pkg::OP_REM: begin
        if (b == 0) r.result = a;
        else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r.result = '0;
        else begin
          q = ma % mb;
          r.result = a[31] ? -q : q;
        end
      end
      rv_alu_pkg::OP_BEQ:  r.branch_taken = (a == b);
      rv_alu_pkg::OP_BNE:  r.branch_taken = (a != b);
      rv_alu_pkg::OP_BLT:  r.branch_taken = signed_less(a, b);
      rv_alu_pkg::OP_BLTU: r.branch_taken = (a < b);
      rv_alu_pkg::OP_BGE:  r.branch_taken = !signed_less(a, b);
      rv_alu_pkg::OP_BGEU: r.branch_taken = (a >= b);
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  // Queue a prediction per accepted item and compare each strobed result.
  always @(posedge clk) begin
    rv_alu_pkg::out_item_t exp_item;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: result %h/%b with none expected",
                     out_data.result, out_data.branch_taken);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.result !== exp_item.result ||
              out_data.branch_taken !== exp_item.branch_taken) begin
            if (fail_count < 10)
              $display("ERROR: expected result %h taken %b, got %h taken %b",
                       exp_item.result, exp_item.branch_taken,
                       out_data.result, out_data.branch_taken);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(alu_predict(in_data));
    end
  end

endmodule

@@ tb/tb_rv32im_execute_alu.sv @@
`timescale 1ns / 1ps
// Top of the RV32IM execute ALU testbench: clock, reset, stimulus and verdict.
// Depends on rv_alu_pkg, rv32im_execute_alu and rv32im_alu_checker.
module tb_rv32im_execute_alu;

  localparam int ALU_LATENCY = 36;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1850;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  rv_alu_pkg::in_item_t  in_data;
  logic                  out_valid;
  rv_alu_pkg::out_item_t out_data;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles;

  rv32im_execute_alu DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  rv32im_alu_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Picks an operand, often from the corner values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h1;
      5: return $urandom_range(0, 64);
      default: return $urandom();
    endcase
  endfunction

  // Offers one item after a random gap if use_gap is set, holding it until the block takes it.
  task automatic send_item(logic [4:0] op, logic [31:0] a, logic [31:0] b, bit use_gap);
    int gap;
    gap = use_gap ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= '{op: op, operand_a: a, operand_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] a, b;
    logic [4:0] op;
    bit burst;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: every operation once, divide corners and an unused code.
    for (int k = 0; k <= 24; k++) send_item(k[4:0], 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_item(rv_alu_pkg::OP_DIVU, 32'h1234_5678, 32'h0, 0);
    send_item(rv_alu_pkg::OP_REMU, 32'hFFFF_FFFF, 32'h0, 0);
    send_item(rv_alu_pkg::OP_DIV, 32'h8765_4321, 32'h0, 0);
    send_item(rv_alu_pkg::OP_REM, 32'h8765_4321, 32'h0, 0);
    send_item(rv_alu_pkg::OP_SRA, 32'h8000_0001, 32'hFFFF_FFE1, 0);
    send_item(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

    // Random part with bursts that keep start high and stretches with gaps.
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 49) == 0) burst = !burst;
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, 24));
      a = pick_operand();
      b = pick_operand();
      send_item(op, a, b, !burst);
    end
    start <= 1'b0;

    // Drain: wait for all expected results, then for any stray results, and give the verdict.
    while (pending != 0) @(posedge clk);
    repeat (ALU_LATENCY + 4) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
